>>> src/life_generation_row_stream_defines.svh
// Assertion macros shared by the row stream RTL
`ifndef LIFE_GENERATION_ROW_STREAM_DEFINES_SVH
`define LIFE_GENERATION_ROW_STREAM_DEFINES_SVH

// check outside reset
`define LGRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define LGRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lgrs_pkg.sv
// Package: shared widths and the job control struct of the row stream
`timescale 1ns / 1ps
`default_nettype none
package lgrs_pkg;

  localparam int ROW_W     = 60;
  localparam int ROW_NUM_W = 6;

  typedef struct packed {
    logic [ROW_NUM_W-1:0] row_idx;
    logic                 has_first;
    logic                 last;
  } job_ctl_t;

endpackage
`default_nettype wire

>>> src/lgrs_in_if.sv
// Interface: input row channel
`timescale 1ns / 1ps
`default_nettype none
interface lgrs_in_if;
  import lgrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;
  logic             final_row;

  modport source (output valid, output row_cells, output final_row, input ready);
  modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface
`default_nettype wire

>>> src/lgrs_out_if.sv
// Interface: result row channel
`timescale 1ns / 1ps
`default_nettype none
interface lgrs_out_if;
  import lgrs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ROW_W-1:0]     next_row_cells;
  logic [ROW_NUM_W-1:0] row_number;
  logic                 frame_done;

  modport source (output valid, output next_row_cells, output row_number,
                  output frame_done, input ready);
  modport sink   (input valid, input next_row_cells, input row_number,
                  input frame_done, output ready);
endinterface
`default_nettype wire

>>> src/lgrs_front.sv
// Front: row window state and job classification
`timescale 1ns / 1ps
`default_nettype none
module lgrs_front #(
  parameter int ACT_W           = 60,
  parameter int GRID_HEIGHT_MAX = 40
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            acc,
  input  wire logic [lgrs_pkg::ROW_W-1:0]      row_cells,
  input  wire logic                            final_row,
  output logic                                 push,
  output lgrs_pkg::job_ctl_t                   push_ctl,
  output logic [3*ACT_W-1:0]                   push_rows
);
  import lgrs_pkg::*;

  logic [ACT_W-1:0]     upper_r, upper_nxt;
  logic [ACT_W-1:0]     middle_r, middle_nxt;
  logic [ROW_NUM_W-1:0] rows_seen_r, rows_seen_nxt;
  logic [ACT_W-1:0]     low;
  logic [ROW_NUM_W:0]   seen_inc;
  logic                 last;
  logic                 has_first;

  assign low       = row_cells[ACT_W-1:0];
  assign seen_inc  = {1'b0, rows_seen_r} + {{ROW_NUM_W{1'b0}}, 1'b1};
  assign last      = final_row || (seen_inc >= (ROW_NUM_W+1)'(GRID_HEIGHT_MAX));
  assign has_first = (rows_seen_r != '0);

  assign push      = acc && (has_first || last);
  assign push_ctl  = '{row_idx: rows_seen_r, has_first: has_first, last: last};
  assign push_rows = {low, middle_r, upper_r};

  always_comb begin
    upper_nxt     = upper_r;
    middle_nxt    = middle_r;
    rows_seen_nxt = rows_seen_r;
    if (acc) begin
      if (last) begin
        upper_nxt     = '0;
        middle_nxt    = '0;
        rows_seen_nxt = '0;
      end else begin
        upper_nxt     = middle_r;
        middle_nxt    = low;
        rows_seen_nxt = seen_inc[ROW_NUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= '0;
      middle_r    <= '0;
      rows_seen_r <= '0;
    end else begin
      upper_r     <= upper_nxt;
      middle_r    <= middle_nxt;
      rows_seen_r <= rows_seen_nxt;
    end
  end
endmodule
`default_nettype wire

>>> src/lgrs_queue.sv
// Queue: two-entry job buffer between front and back
`timescale 1ns / 1ps
`default_nettype none
module lgrs_queue #(
  parameter int ACT_W = 60
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lgrs_pkg::job_ctl_t   push_ctl,
  input  wire logic [3*ACT_W-1:0]   push_rows,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output lgrs_pkg::job_ctl_t        head_ctl,
  output logic [3*ACT_W-1:0]        head_rows
);
  import lgrs_pkg::*;
  `include "life_generation_row_stream_defines.svh"

  localparam int DEPTH = 2;

  job_ctl_t         ctl_r  [DEPTH];
  logic [3*ACT_W-1:0] rows_r [DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full       = (count_r == 2'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_ctl   = ctl_r[rd_ptr_r];
  assign head_rows  = rows_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wr_ptr_r]  <= push_ctl;
      rows_r[wr_ptr_r] <= push_rows;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `LGRS_ASSERT(a_no_overflow, !(push && full && !pop), "job queue overflow")
  `LGRS_ASSERT(a_no_underflow, !(pop && !head_valid), "job queue underflow")
  `LGRS_ASSERT(a_count_range, count_r <= 2'(DEPTH), "job queue count out of range")
  `LGRS_ASSERT(a_ptr_match, (count_r == '0 || count_r == 2'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r),
    "job queue pointers out of step")
endmodule
`default_nettype wire

>>> src/lgrs_back.sv
// Back: cell lanes for one generation row and the output register
`timescale 1ns / 1ps
`default_nettype none
module lgrs_back #(
  parameter int ACT_W = 60
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           head_valid,
  input  wire lgrs_pkg::job_ctl_t             head_ctl,
  input  wire logic [3*ACT_W-1:0]             head_rows,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lgrs_pkg::ROW_W-1:0]          out_cells,
  output logic [lgrs_pkg::ROW_NUM_W-1:0]      out_row,
  output logic                                out_done
);
  import lgrs_pkg::*;
  `include "life_generation_row_stream_defines.svh"

  logic                 phase_r, phase_nxt;
  logic                 valid_r, valid_nxt;
  logic [ROW_W-1:0]     cells_r;
  logic [ROW_NUM_W-1:0] row_r;
  logic                 done_r;

  logic [ACT_W-1:0]     up, mid, low;
  logic                 second;
  logic [ACT_W-1:0]     r0, r1, r2;
  logic [ACT_W+1:0]     p0, p1, p2;
  logic [ACT_W-1:0]     res;
  logic [ROW_W-1:0]     res_wide;
  logic                 load;
  logic                 retire;

  assign up  = head_rows[ACT_W-1:0];
  assign mid = head_rows[2*ACT_W-1:ACT_W];
  assign low = head_rows[3*ACT_W-1:2*ACT_W];

  // second result of a bottom row uses a dead row below
  assign second = !(head_ctl.has_first && !phase_r);
  assign r0 = second ? mid : up;
  assign r1 = second ? low : mid;
  assign r2 = second ? '0  : low;
  assign p0 = {1'b0, r0, 1'b0};
  assign p1 = {1'b0, r1, 1'b0};
  assign p2 = {1'b0, r2, 1'b0};

  for (genvar k = 0; k < ACT_W; k++) begin : g_lane
    logic [3:0] n;
    assign n = 4'(p0[k]) + 4'(p0[k+1]) + 4'(p0[k+2])
             + 4'(p1[k]) + 4'(p1[k+2])
             + 4'(p2[k]) + 4'(p2[k+1]) + 4'(p2[k+2]);
    assign res[k] = (n == 4'd3) || ((n == 4'd2) && p1[k+1]);
  end

  always_comb begin
    res_wide = '0;
    res_wide[ACT_W-1:0] = res;
  end

  assign load   = head_valid && (!valid_r || out_ready);
  assign retire = second || !head_ctl.last;
  assign pop    = load && retire;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = !retire;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cells_r <= res_wide;
      row_r   <= second ? head_ctl.row_idx : head_ctl.row_idx - ROW_NUM_W'(1);
      done_r  <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cells = cells_r;
  assign out_row   = row_r;
  assign out_done  = done_r;

  `LGRS_ASSERT(a_phase_has_job, phase_r |-> head_valid, "split job lost its queue entry")
  `LGRS_ASSERT(a_phase_bottom, phase_r |-> (head_ctl.last && head_ctl.has_first),
    "split job is not a bottom row")
  `LGRS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!valid_r && !phase_r),
    "output stage not cleared by reset")
endmodule
`default_nettype wire

>>> src/life_generation_row_stream.sv
// Top level: one Game of Life generation over a row-streamed grid
//
//  channel  | dir | payload                                  | handshake
//  in_ch    | in  | row_cells[59:0], final_row               | valid/ready
//  out_ch   | out | next_row_cells[59:0], row_number[5:0],   | valid/ready
//           |     | frame_done                               |
//
// One row accepted per cycle while the queue is not full; each row yields
// zero, one or two result rows. Each result passes the job queue and then
// the single output register; a bottom row gives its two results in turn.
// A two-entry job queue decouples input acceptance from output stalls.
// Synchronous active-low reset clears the row window, the queue and output.
`timescale 1ns / 1ps
`default_nettype none
module life_generation_row_stream #(
  parameter int GRID_WIDTH      = 60,
  parameter int GRID_HEIGHT_MAX = 40
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lgrs_in_if.sink     in_ch,
  lgrs_out_if.source  out_ch
);
  import lgrs_pkg::*;

  localparam int ACT_W = (GRID_WIDTH < ROW_W) ? GRID_WIDTH : ROW_W;

  logic               full;
  logic               acc;
  logic               push;
  job_ctl_t           push_ctl;
  logic [3*ACT_W-1:0] push_rows;
  logic               pop;
  logic               head_valid;
  job_ctl_t           head_ctl;
  logic [3*ACT_W-1:0] head_rows;

  assign in_ch.ready = !full;
  assign acc         = in_ch.valid && !full;

  lgrs_front #(
    .ACT_W           (ACT_W),
    .GRID_HEIGHT_MAX (GRID_HEIGHT_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .row_cells (in_ch.row_cells),
    .final_row (in_ch.final_row),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_rows (push_rows)
  );

  lgrs_queue #(
    .ACT_W (ACT_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_rows  (push_rows),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_rows  (head_rows)
  );

  lgrs_back #(
    .ACT_W (ACT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_rows  (head_rows),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_cells  (out_ch.next_row_cells),
    .out_row    (out_ch.row_number),
    .out_done   (out_ch.frame_done)
  );
endmodule
`default_nettype wire
